// File: hdl/pfe_pkg.sv
// Package for the palette fade engine: item types, command and mode codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int ENTRIES_DEFAULT = 64;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_FADE_IN  = 3'd1;
    localparam logic [2:0] CMD_FADE_OUT = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_FADE_IN  = 2'd1;
    localparam logic [1:0] MODE_FADE_OUT = 2'd2;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CHANNELS = 2'd3;

    localparam logic [7:0] WHITE_LEVEL       = 8'd224;
    localparam logic [7:0] STEP              = 8'd32;
    localparam logic [3:0] TICKS_PER_CHANNEL = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0] command;
        logic [5:0] entry_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [1:0] fade_state;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic sweep_rd;
        logic sweep_end;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_req;
        logic sweep_last;
    } dp_status_t;

endpackage

// File: hdl/pfe_datapath.sv
// Datapath of the palette fade engine: palette and saved-palette memories,
// fade registers, sweep counter, write-back pipeline and result register.
// Depends on pfe_pkg.
`timescale 1ns / 1ps

module pfe_datapath #(
    parameter int ENTRIES = pfe_pkg::ENTRIES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pfe_pkg::in_item_t      item,
    input  pfe_pkg::ctrl_cmd_t     cmd,
    output pfe_pkg::dp_status_t    status,
    output pfe_pkg::out_item_t     result
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
    localparam logic [8:0] DEPTH = 9'(ENTRIES);

    function automatic logic [7:0] get_chan(input logic [23:0] word, input logic [1:0] ch);
        logic [7:0] v;
        case (ch)
            pfe_pkg::CH_RED:   v = word[23:16];
            pfe_pkg::CH_GREEN: v = word[15:8];
            default:           v = word[7:0];
        endcase
        return v;
    endfunction

    function automatic logic [23:0] put_chan(input logic [23:0] word, input logic [1:0] ch,
                                             input logic [7:0] v);
        logic [23:0] w;
        w = word;
        case (ch)
            pfe_pkg::CH_RED:   w[23:16] = v;
            pfe_pkg::CH_GREEN: w[15:8]  = v;
            default:           w[7:0]   = v;
        endcase
        return w;
    endfunction

    logic [23:0] pal_mem [ENTRIES];
    logic [23:0] sav_mem [ENTRIES];

    pfe_pkg::in_item_t  item_reg;
    pfe_pkg::out_item_t result_reg;

    logic [1:0]    mode_reg, mode_next;
    logic [3:0]    tick_reg, tick_next;
    logic [1:0]    chan_reg, chan_next;
    logic [7:0]    floor_reg, floor_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          wr_valid_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [23:0]   pal_rdata_reg;
    logic [23:0]   sav_rdata_reg;

    logic [8:0]    idx_ext;
    logic          in_range;
    logic [AW-1:0] idx_addr;
    logic          active;
    logic [AW-1:0] pal_raddr;
    logic          pal_we;
    logic [AW-1:0] pal_waddr;
    logic [23:0]   pal_wdata;
    logic          sav_we;
    logic [7:0]    cur_pal;
    logic [7:0]    cur_sav;
    logic [7:0]    faded_in;
    logic [7:0]    faded_out;
    logic [23:0]   sweep_word;

    assign idx_ext  = {3'b000, item_reg.entry_index};
    assign in_range = idx_ext < DEPTH;
    assign idx_addr = idx_ext[AW-1:0];
    assign active   = (mode_reg == pfe_pkg::MODE_FADE_IN) || (mode_reg == pfe_pkg::MODE_FADE_OUT);

    assign status.sweep_req = (item_reg.command == pfe_pkg::CMD_FADE_IN) ||
                              ((item_reg.command == pfe_pkg::CMD_TICK) && active &&
                               (chan_reg < pfe_pkg::CHANNELS) && (tick_reg != 4'd0));
    assign status.sweep_last = (cnt_reg == LAST_ADDR);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        tick_next  = tick_reg;
        chan_next  = chan_reg;
        floor_next = floor_reg;
        if (cmd.exec)
        begin
            case (item_reg.command)
                pfe_pkg::CMD_TICK:
                begin
                    if (active)
                    begin
                        if (chan_reg >= pfe_pkg::CHANNELS)
                        begin
                            mode_next = pfe_pkg::MODE_IDLE;
                        end
                        else if (tick_reg == 4'd0)
                        begin
                            tick_next = pfe_pkg::TICKS_PER_CHANNEL;
                            chan_next = chan_reg + 2'd1;
                            if (mode_reg == pfe_pkg::MODE_FADE_IN)
                            begin
                                floor_next = pfe_pkg::WHITE_LEVEL;
                            end
                        end
                    end
                end
                pfe_pkg::CMD_FADE_OUT:
                begin
                    mode_next = pfe_pkg::MODE_FADE_OUT;
                    tick_next = pfe_pkg::TICKS_PER_CHANNEL;
                    chan_next = pfe_pkg::CH_RED;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.sweep_end)
        begin
            if (item_reg.command == pfe_pkg::CMD_FADE_IN)
            begin
                mode_next  = pfe_pkg::MODE_FADE_IN;
                tick_next  = pfe_pkg::TICKS_PER_CHANNEL;
                chan_next  = pfe_pkg::CH_RED;
                floor_next = pfe_pkg::WHITE_LEVEL;
            end
            else
            begin
                tick_next = tick_reg - 4'd1;
                if (mode_reg == pfe_pkg::MODE_FADE_IN)
                begin
                    floor_next = floor_reg - pfe_pkg::STEP;
                end
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.capture)
        begin
            cnt_next = '0;
        end
        else if (cmd.sweep_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= pfe_pkg::MODE_IDLE;
            tick_reg     <= pfe_pkg::TICKS_PER_CHANNEL;
            chan_reg     <= pfe_pkg::CH_RED;
            floor_reg    <= pfe_pkg::WHITE_LEVEL;
            cnt_reg      <= '0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            tick_reg     <= tick_next;
            chan_reg     <= chan_next;
            floor_reg    <= floor_next;
            cnt_reg      <= cnt_next;
            wr_valid_reg <= cmd.sweep_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= cnt_reg;
    end

    assign cur_pal   = get_chan(pal_rdata_reg, chan_reg);
    assign cur_sav   = get_chan(sav_rdata_reg, chan_reg);
    assign faded_in  = (cur_sav < floor_reg) ? floor_reg : cur_sav;
    assign faded_out = (cur_pal < pfe_pkg::WHITE_LEVEL) ? (cur_pal + pfe_pkg::STEP) : cur_pal;

    always_comb
    begin
        if (item_reg.command == pfe_pkg::CMD_FADE_IN)
        begin
            sweep_word = {3{pfe_pkg::WHITE_LEVEL}};
        end
        else if (mode_reg == pfe_pkg::MODE_FADE_IN)
        begin
            sweep_word = put_chan(pal_rdata_reg, chan_reg, faded_in);
        end
        else
        begin
            sweep_word = put_chan(pal_rdata_reg, chan_reg, faded_out);
        end
    end

    assign pal_raddr = cmd.sweep_rd ? cnt_reg : idx_addr;
    assign pal_we    = wr_valid_reg ||
                       (cmd.exec && (item_reg.command == pfe_pkg::CMD_WRITE) && in_range);
    assign pal_waddr = wr_valid_reg ? wr_addr_reg : idx_addr;
    assign pal_wdata = wr_valid_reg ? sweep_word
                                    : {item_reg.red_in, item_reg.green_in, item_reg.blue_in};
    assign sav_we    = wr_valid_reg && (item_reg.command == pfe_pkg::CMD_FADE_IN);

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[pal_waddr] <= pal_wdata;
        end
        pal_rdata_reg <= pal_mem[pal_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sav_we)
        begin
            sav_mem[wr_addr_reg] <= pal_rdata_reg;
        end
        sav_rdata_reg <= sav_mem[cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if ((item_reg.command == pfe_pkg::CMD_READ) && in_range)
            begin
                result_reg.red_out   <= pal_rdata_reg[23:16];
                result_reg.green_out <= pal_rdata_reg[15:8];
                result_reg.blue_out  <= pal_rdata_reg[7:0];
            end
            else
            begin
                result_reg.red_out   <= 8'd0;
                result_reg.green_out <= 8'd0;
                result_reg.blue_out  <= 8'd0;
            end
            result_reg.fade_state <= mode_reg;
        end
    end

    assign result = result_reg;

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != 2'd3)
        else $error("fade mode holds an unused code");

    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg <= pfe_pkg::TICKS_PER_CHANNEL)
        else $error("tick count above its start value");

    a_chan_done: assert property (@(posedge clk) disable iff (!rst_n)
        (chan_reg == pfe_pkg::CHANNELS) |-> (tick_reg == pfe_pkg::TICKS_PER_CHANNEL))
        else $error("channel index past blue with a partial tick count");

    a_floor_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_end && (item_reg.command == pfe_pkg::CMD_TICK) &&
         (mode_reg == pfe_pkg::MODE_FADE_IN))
        |=> (floor_reg == $past(floor_reg) - pfe_pkg::STEP))
        else $error("fade-in floor did not fall by one step");

endmodule

// File: hdl/pfe_ctrl.sv
// Controller state machine of the palette fade engine: input and output
// handshakes, sweep sequencing and result loading.
// Depends on pfe_pkg.
`timescale 1ns / 1ps

module pfe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    output logic                result_valid,
    input  logic                result_stall,
    input  pfe_pkg::dp_status_t status,
    output pfe_pkg::ctrl_cmd_t  cmd
);

    pfe_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfe_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = pfe_pkg::ST_DECODE;
                end
            end
            pfe_pkg::ST_DECODE:
            begin
                state_next = status.sweep_req ? pfe_pkg::ST_SWEEP : pfe_pkg::ST_DONE;
            end
            pfe_pkg::ST_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next = pfe_pkg::ST_DRAIN;
                end
            end
            pfe_pkg::ST_DRAIN:
            begin
                state_next = pfe_pkg::ST_DONE;
            end
            pfe_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = pfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall    = (state_reg != pfe_pkg::ST_IDLE);
        cmd.capture   = (state_reg == pfe_pkg::ST_IDLE) && item_valid;
        cmd.exec      = (state_reg == pfe_pkg::ST_DECODE) && !status.sweep_req;
        cmd.sweep_rd  = (state_reg == pfe_pkg::ST_SWEEP);
        cmd.sweep_end = (state_reg == pfe_pkg::ST_DRAIN);
        cmd.load_out  = (state_reg == pfe_pkg::ST_DONE) && out_free;
        result_valid  = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfe_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && result_stall))
        else $error("result loaded over one still waiting");

    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == pfe_pkg::ST_DONE))
        else $error("result shown without finishing an item");

    a_sweep_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_rd || cmd.sweep_end) |-> !cmd.capture)
        else $error("item captured during a sweep");

endmodule

// File: hdl/palette_fade_engine_top.sv
// Top level of the palette fade engine: joins the controller and the datapath.
// Depends on pfe_pkg, pfe_ctrl and pfe_datapath.
//
// Usage: items enter on item/item_valid/item_stall and results leave on
// result/result_valid/result_stall; a transfer happens when valid is high and
// stall is low. Every item gives exactly one result, in order.
// Write, read, start fade-out, unused codes and ticks that only change the
// fade counters go from decode straight to the done state, where the result is
// loaded once the result register is free, and the next item is taken in idle.
// Start fade-in and every working fade tick sweep the palette memories one
// entry per cycle through a single read and a single write port, passing through
// the sweep and drain states before done.
// One item is in progress at a time; the result register lets a new item be
// accepted while the previous result is still stalled, and the engine then
// holds its next result until the register is taken.
// Reset clears the fade state to idle with channel red, eight ticks and a
// floor of 224; the palette contents stay undefined until written.
`timescale 1ns / 1ps

module palette_fade_engine_top #(
    parameter int ENTRIES = pfe_pkg::ENTRIES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  pfe_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output pfe_pkg::out_item_t result
);

    pfe_pkg::ctrl_cmd_t  cmd;
    pfe_pkg::dp_status_t status;

    pfe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    pfe_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for palette_fade_engine_top: it drives random and directed
// palette commands and checks every result against a predictor of the palette and fade.
// Depends on pfe_pkg and the RTL of palette_fade_engine_top.
`timescale 1ns / 1ps

module tb_top;

    localparam int N_ENTRIES = pfe_pkg::ENTRIES_DEFAULT;
    localparam int RANDOM_ITEMS = 1350;
    localparam int IDLE_PCT = 34;

    class fade_scoreboard;
        logic [23:0] palette [N_ENTRIES];
        logic [23:0] saved [N_ENTRIES];
        logic [1:0] mode = pfe_pkg::MODE_IDLE;
        logic [3:0] ticks_left = pfe_pkg::TICKS_PER_CHANNEL;
        logic [1:0] channel = pfe_pkg::CH_RED;
        logic [7:0] floor_level = pfe_pkg::WHITE_LEVEL;
        pfe_pkg::out_item_t pending_colors[$];
        int failures = 0;

        function void advance_fade();
            int i;
            int sh;
            logic [7:0] v;
            if (mode != pfe_pkg::MODE_FADE_IN && mode != pfe_pkg::MODE_FADE_OUT)
                return;
            if (channel >= pfe_pkg::CHANNELS)
            begin
                mode = pfe_pkg::MODE_IDLE;
                return;
            end
            if (ticks_left != 0)
            begin
                ticks_left = ticks_left - 1;
                sh = 16 - 8 * channel;
                for (i = 0; i < N_ENTRIES; i++)
                begin
                    if (mode == pfe_pkg::MODE_FADE_IN)
                    begin
                        v = saved[i][sh +: 8];
                        if (v < floor_level)
                            v = floor_level;
                    end
                    else
                    begin
                        v = palette[i][sh +: 8];
                        if (v < pfe_pkg::WHITE_LEVEL)
                            v = v + pfe_pkg::STEP;
                    end
                    palette[i][sh +: 8] = v;
                end
                if (mode == pfe_pkg::MODE_FADE_IN)
                    floor_level = floor_level - pfe_pkg::STEP;
                return;
            end
            ticks_left = pfe_pkg::TICKS_PER_CHANNEL;
            if (mode == pfe_pkg::MODE_FADE_IN)
                floor_level = pfe_pkg::WHITE_LEVEL;
            channel = channel + 1;
        endfunction

        function pfe_pkg::out_item_t apply_command(pfe_pkg::in_item_t it);
            pfe_pkg::out_item_t res;
            int i;
            res = '0;
            case (it.command)
                pfe_pkg::CMD_TICK:
                    advance_fade();
                pfe_pkg::CMD_FADE_IN:
                begin
                    for (i = 0; i < N_ENTRIES; i++)
                    begin
                        saved[i] = palette[i];
                        palette[i] = {pfe_pkg::WHITE_LEVEL, pfe_pkg::WHITE_LEVEL,
                                      pfe_pkg::WHITE_LEVEL};
                    end
                    mode = pfe_pkg::MODE_FADE_IN;
                    ticks_left = pfe_pkg::TICKS_PER_CHANNEL;
                    channel = pfe_pkg::CH_RED;
                    floor_level = pfe_pkg::WHITE_LEVEL;
                end
                pfe_pkg::CMD_FADE_OUT:
                begin
                    mode = pfe_pkg::MODE_FADE_OUT;
                    ticks_left = pfe_pkg::TICKS_PER_CHANNEL;
                    channel = pfe_pkg::CH_RED;
                end
                pfe_pkg::CMD_WRITE:
                    palette[it.entry_index] = {it.red_in, it.green_in, it.blue_in};
                pfe_pkg::CMD_READ:
                    {res.red_out, res.green_out, res.blue_out} = palette[it.entry_index];
                default:
                    ;
            endcase
            res.fade_state = mode;
            return res;
        endfunction

        function void note_item(pfe_pkg::in_item_t it);
            pending_colors.push_back(apply_command(it));
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
                failures++;
            end
        endfunction

        function void check_result(pfe_pkg::out_item_t got);
            pfe_pkg::out_item_t want;
            if (pending_colors.size() == 0)
            begin
                $display("%0t: result expected none, actual %h", $time, got);
                failures++;
                return;
            end
            want = pending_colors.pop_front();
            compare("red_out", want.red_out, got.red_out);
            compare("green_out", want.green_out, got.green_out);
            compare("blue_out", want.blue_out, got.blue_out);
            compare("fade_state", {6'd0, want.fade_state}, {6'd0, got.fade_state});
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    pfe_pkg::in_item_t item;
    logic result_valid;
    logic result_stall;
    pfe_pkg::out_item_t result;

    int idle_pct = IDLE_PCT;
    int counted = 0;
    fade_scoreboard sb = new();

    palette_fade_engine_top i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic pfe_pkg::in_item_t make_item(logic [2:0] cmd, logic [5:0] idx,
                                                     logic [23:0] rgb);
        pfe_pkg::in_item_t it;
        it.command = cmd;
        it.entry_index = idx;
        {it.red_in, it.green_in, it.blue_in} = rgb;
        return it;
    endfunction

    // Levels cluster around the fade thresholds so that the saturation cases are hit.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(3))
            0: return 8'($urandom);
            1: return {3'($urandom_range(7)), 5'd0};
            2: return 8'(8'd222 + $urandom_range(3));
            default: return {3'($urandom_range(7)), 5'h1f};
        endcase
    endfunction

    function automatic logic [23:0] pick_color();
        return {pick_level(), pick_level(), pick_level()};
    endfunction

    task automatic send_item(input pfe_pkg::in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        counted++;
        sb.note_item(it);
    endtask

    task automatic send_cmd(input logic [2:0] cmd);
        send_item(make_item(cmd, 6'($urandom), 24'($urandom)));
    endtask

    task automatic write_entry(input logic [5:0] idx, input logic [23:0] rgb);
        send_item(make_item(pfe_pkg::CMD_WRITE, idx, rgb));
    endtask

    task automatic read_entry(input logic [5:0] idx);
        send_item(make_item(pfe_pkg::CMD_READ, idx, 24'($urandom)));
    endtask

    task automatic wait_drained();
        while (sb.pending_colors.size() != 0)
            @(posedge clk);
    endtask

    task automatic fade_sequence();
        int n_ticks;
        int t;
        send_cmd($urandom_range(1) ? pfe_pkg::CMD_FADE_IN : pfe_pkg::CMD_FADE_OUT);
        if ($urandom_range(4) == 0)
            n_ticks = $urandom_range(1, 28);
        else
            n_ticks = 29 + $urandom_range(1);
        for (t = 0; t < n_ticks; t++)
        begin
            send_cmd(pfe_pkg::CMD_TICK);
            while ($urandom_range(9) < 4)
            begin
                if ($urandom_range(4) == 0)
                    write_entry(6'($urandom), pick_color());
                else
                    read_entry(6'($urandom));
            end
        end
    endtask

    task automatic noise_items();
        int n;
        int k;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
            send_item(make_item(3'($urandom_range(7)), 6'($urandom), pick_color()));
    endtask

    initial
    begin
        forever
        begin
            result_stall <= ($urandom_range(99) < idle_pct);
            @(posedge clk);
            if (result_valid === 1'b1 && result_stall === 1'b0)
                sb.check_result(result);
        end
    end

    initial
    begin
        #12_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        int i;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Every entry is written before anything can read or save it.
        for (i = 0; i < N_ENTRIES; i++)
        begin
            if (i == 0)
                write_entry(6'(i), 24'h000000);
            else if (i == N_ENTRIES - 1)
                write_entry(6'(i), 24'hffffff);
            else
                write_entry(6'(i), pick_color());
        end

        read_entry(6'd0);
        read_entry(6'd63);
        send_cmd(pfe_pkg::CMD_TICK);
        send_cmd(3'd5);
        send_cmd(3'd6);
        send_cmd(3'd7);
        write_entry(6'd5, 24'hdf00e0);
        send_cmd(pfe_pkg::CMD_FADE_IN);
        read_entry(6'd5);
        send_cmd(pfe_pkg::CMD_TICK);
        send_cmd(pfe_pkg::CMD_TICK);
        read_entry(6'd0);
        read_entry(6'd5);
        write_entry(6'd7, 24'h00ff20);
        send_cmd(pfe_pkg::CMD_TICK);
        read_entry(6'd7);
        send_cmd(pfe_pkg::CMD_FADE_OUT);
        send_cmd(pfe_pkg::CMD_TICK);
        send_cmd(pfe_pkg::CMD_TICK);
        read_entry(6'd7);
        read_entry(6'd63);
        send_cmd(pfe_pkg::CMD_FADE_IN);
        send_cmd(pfe_pkg::CMD_TICK);
        read_entry(6'd0);

        item_valid <= 1'b0;
        wait_drained();

        while (counted < RANDOM_ITEMS)
        begin
            if (counted > 500 && counted < 700)
                idle_pct = 0;
            else
                idle_pct = IDLE_PCT;
            if ($urandom_range(4) != 0)
                fade_sequence();
            else
                noise_items();
            if ($urandom_range(19) == 0)
            begin
                item_valid <= 1'b0;
                wait_drained();
            end
        end

        idle_pct = IDLE_PCT;
        item_valid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge clk);
        if (sb.failures == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
